### src/fixed_point_alu_tolerant_compare_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fixed-point ALU with tolerant compare
// Shared property forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_TOLERANT_COMPARE_UNIT_ASSERT_SVH
`define FIXED_POINT_ALU_TOLERANT_COMPARE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fixed-point ALU check failed");

// The consequent must hold in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fixed-point ALU check failed");

`endif

### src/fpa_tc_pkg.sv
// ---------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes and the payload types of the input and result channels.
// ---------------------------------------------------------------------------
package fpa_tc_pkg;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               greater_flag;
        logic               less_flag;
        logic               equal_flag;
        logic               divide_by_zero;
    } out_item_t;

    // Fields that ride alongside the divider stages.
    typedef struct packed {
        mode_t       mode;
        logic        neg;
        logic [31:0] simple;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        dz;
    } pass_t;

endpackage

### src/fixed_point_alu_tolerant_compare_unit.sv
// ---------------------------------------------------------------------------
// Fixed-point ALU with tolerant compare
// Add, subtract, multiply and divide on signed fixed-point words, with
// greater, less and equal flags taken within a programmable tolerance.
// ---------------------------------------------------------------------------
// The unit takes one transfer per cycle while the result side does not stall and
// returns one result per item, in order.
// The restoring divider resolves one quotient bit per pipeline stage over
// 32 + FRAC_BITS stages; every operation travels the same stages so results
// never pass each other. A stall on the result side freezes the whole pipeline
// while the result register is full.
module fixed_point_alu_tolerant_compare_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_enable,
    input  logic [7:0]            cfg_write_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  fpa_tc_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output fpa_tc_pkg::out_item_t out_data
);

    localparam int QW = 32 + FRAC_BITS;

    logic [7:0] tol_reg;
    logic       adv;

    // Stage 0: input register.
    logic                 s0_valid_reg;
    fpa_tc_pkg::in_item_t s0_item_reg;

    // Stage 1: magnitudes, product and compare flags.
    logic              s1_valid_reg;
    fpa_tc_pkg::pass_t s1_pass_reg;
    logic [31:0]       s1_mag_a_reg;
    logic [31:0]       s1_mag_b_reg;
    logic [63:0]       s1_prod_reg;
    fpa_tc_pkg::pass_t s1_pass_next;
    logic [31:0]       mag_a;
    logic [31:0]       mag_b;
    logic signed [33:0] a_ext;
    logic signed [33:0] b_ext;
    logic signed [33:0] t_ext;
    logic signed [33:0] diff;

    // Divider stages; index 0 is the load stage.
    logic              dv_valid_reg [0:QW];
    fpa_tc_pkg::pass_t dv_pass_reg  [0:QW];
    logic [31:0]       dv_rem_reg   [0:QW];
    logic [31:0]       dv_den_reg   [0:QW];
    logic [QW-1:0]     dv_num_reg   [0:QW];
    logic [QW-1:0]     dv_quo_reg   [0:QW];
    fpa_tc_pkg::pass_t dv0_pass_next;

    logic                  out_valid_reg;
    fpa_tc_pkg::out_item_t out_item_reg;
    fpa_tc_pkg::out_item_t out_item_next;
    logic [31:0]           quo_low;

    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= 8'd0;
        end
        else if (cfg_write_enable)
        begin
            tol_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_item_reg <= in_data;
        end
    end

    always_comb
    begin
        mag_a = s0_item_reg.operand_a[31] ? 32'd0 - s0_item_reg.operand_a
                                          : s0_item_reg.operand_a;
        mag_b = s0_item_reg.operand_b[31] ? 32'd0 - s0_item_reg.operand_b
                                          : s0_item_reg.operand_b;
        a_ext = 34'(s0_item_reg.operand_a);
        b_ext = 34'(s0_item_reg.operand_b);
        t_ext = 34'($signed({1'b0, tol_reg}));

        s1_pass_next.mode = s0_item_reg.mode;
        s1_pass_next.neg  = s0_item_reg.operand_a[31] ^ s0_item_reg.operand_b[31];
        unique case (s0_item_reg.mode)
            fpa_tc_pkg::MODE_SUB:
                s1_pass_next.simple = s0_item_reg.operand_a - s0_item_reg.operand_b;
            default:
                s1_pass_next.simple = s0_item_reg.operand_a + s0_item_reg.operand_b;
        endcase
        s1_pass_next.gt = a_ext > (b_ext + t_ext);
        s1_pass_next.lt = (a_ext - t_ext) < b_ext;
        diff = s1_pass_next.gt ? (a_ext - b_ext) : (b_ext - a_ext);
        s1_pass_next.eq = diff <= t_ext;
        s1_pass_next.dz = (s0_item_reg.mode == fpa_tc_pkg::MODE_DIV)
                          && (s0_item_reg.operand_b == 32'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pass_reg  <= s1_pass_next;
            s1_mag_a_reg <= mag_a;
            s1_mag_b_reg <= mag_b;
            s1_prod_reg  <= 64'(mag_a) * 64'(mag_b);
        end
    end

    // Load stage: the scaled product replaces the add/sub result for multiply.
    always_comb
    begin
        dv0_pass_next = s1_pass_reg;
        if (s1_pass_reg.mode == fpa_tc_pkg::MODE_MUL)
        begin
            dv0_pass_next.simple = s1_prod_reg[FRAC_BITS +: 32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_pass_reg[0] <= dv0_pass_next;
            dv_rem_reg[0]  <= 32'd0;
            dv_den_reg[0]  <= s1_mag_b_reg;
            dv_num_reg[0]  <= QW'(s1_mag_a_reg) << FRAC_BITS;
            dv_quo_reg[0]  <= '0;
        end
    end

    // One restoring step per stage, numerator bits taken MSB first.
    for (genvar j = 1; j <= QW; j++)
    begin : g_div
        logic [32:0] rem_shift;
        logic        ge;

        always_comb
        begin
            rem_shift = {dv_rem_reg[j-1], dv_num_reg[j-1][QW-1]};
            ge        = rem_shift >= {1'b0, dv_den_reg[j-1]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_pass_reg[j] <= dv_pass_reg[j-1];
                dv_den_reg[j]  <= dv_den_reg[j-1];
                dv_num_reg[j]  <= dv_num_reg[j-1] << 1;
                dv_quo_reg[j]  <= {dv_quo_reg[j-1][QW-2:0], ge};
                dv_rem_reg[j]  <= ge ? 32'(rem_shift - {1'b0, dv_den_reg[j-1]})
                                     : rem_shift[31:0];
            end
        end
    end

    always_comb
    begin
        quo_low = dv_quo_reg[QW][31:0];
        out_item_next.greater_flag   = dv_pass_reg[QW].gt;
        out_item_next.less_flag      = dv_pass_reg[QW].lt;
        out_item_next.equal_flag     = dv_pass_reg[QW].eq;
        out_item_next.divide_by_zero = dv_pass_reg[QW].dz;
        unique case (dv_pass_reg[QW].mode)
            fpa_tc_pkg::MODE_MUL:
                out_item_next.result_value = dv_pass_reg[QW].neg
                    ? 32'd0 - dv_pass_reg[QW].simple : dv_pass_reg[QW].simple;
            fpa_tc_pkg::MODE_DIV:
                out_item_next.result_value = dv_pass_reg[QW].dz ? 32'd0
                    : (dv_pass_reg[QW].neg ? 32'd0 - quo_low : quo_low);
            default:
                out_item_next.result_value = dv_pass_reg[QW].simple;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

### src/fpa_tc_checker.sv
// ---------------------------------------------------------------------------
// Fixed-point ALU port checker
// Watches the result channel for handshake and flag consistency.
// ---------------------------------------------------------------------------
`include "fixed_point_alu_tolerant_compare_unit_assert.svh"

module fpa_tc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input fpa_tc_pkg::out_item_t out_data
);

    // A stalled result must stay in place until it is taken.
    `FPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    // A zero divisor always yields a zero result.
    `FPA_ASSERT_SAME(a_dz_zero, out_valid && out_data.divide_by_zero, out_data.result_value == 32'sd0)
    // Greater rules out less.
    `FPA_ASSERT_SAME(a_gt_not_lt, out_valid && out_data.greater_flag, !out_data.less_flag)
    // Greater rules out equal.
    `FPA_ASSERT_SAME(a_gt_not_eq, out_valid && out_data.greater_flag, !out_data.equal_flag)

endmodule

bind fixed_point_alu_tolerant_compare_unit fpa_tc_checker u_fpa_tc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

### tb/sv/fixed_point_alu_tolerant_compare_unit_checker.sv
// ---------------------------------------------------------------------------
// Fixed-point ALU result checker
// Watches both channels, predicts each result from the accepted operands and
// the current tolerance, and compares results in order, field by field.
// ---------------------------------------------------------------------------
module fixed_point_alu_tolerant_compare_unit_checker #(
    parameter int FRAC_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_enable,
    input  logic [7:0]            cfg_write_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  fpa_tc_pkg::in_item_t  in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  fpa_tc_pkg::out_item_t out_data,
    output int                    fail_count,
    output int                    pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]            tolerance;
    fpa_tc_pkg::out_item_t expected_results[$];

    assign pending_count = expected_results.size();

    function automatic fpa_tc_pkg::out_item_t alu_result(fpa_tc_pkg::in_item_t item,
                                                         logic [7:0] tol);
        fpa_tc_pkg::out_item_t r;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] t;
        logic signed [63:0] prod;
        logic [63:0]        mag;
        logic [63:0]        num;
        logic [63:0]        den;
        a = item.operand_a;
        b = item.operand_b;
        t = {56'd0, tol};
        r = '0;
        case (item.mode)
            fpa_tc_pkg::MODE_ADD: r.result_value = 32'(a + b);
            fpa_tc_pkg::MODE_SUB: r.result_value = 32'(a - b);
            fpa_tc_pkg::MODE_MUL:
            begin
                prod = a * b;
                mag = prod < 0 ? -prod : prod;
                mag = mag >> FRAC_BITS;
                r.result_value = 32'(prod < 0 ? -mag : mag);
            end
            default:
            begin
                if (b == 0)
                begin
                    r.divide_by_zero = 1'b1;
                end
                else
                begin
                    num = (a < 0 ? -a : a) << FRAC_BITS;
                    den = b < 0 ? -b : b;
                    mag = num / den;
                    r.result_value = 32'(((a < 0) != (b < 0)) ? -mag : mag);
                end
            end
        endcase
        r.greater_flag = a > b + t;
        r.less_flag = a - t < b;
        r.equal_flag = (r.greater_flag ? a - b : b - a) <= t;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fpa_tc_pkg::out_item_t want;
        if (!rst_n)
        begin
            tolerance <= '0;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", out_data.result_value, 32'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.result_value !== want.result_value)
                        report_mismatch("result_value", out_data.result_value,
                                        want.result_value);
                    if (out_data.greater_flag !== want.greater_flag)
                        report_mismatch("greater_flag", 32'(out_data.greater_flag),
                                        32'(want.greater_flag));
                    if (out_data.less_flag !== want.less_flag)
                        report_mismatch("less_flag", 32'(out_data.less_flag),
                                        32'(want.less_flag));
                    if (out_data.equal_flag !== want.equal_flag)
                        report_mismatch("equal_flag", 32'(out_data.equal_flag),
                                        32'(want.equal_flag));
                    if (out_data.divide_by_zero !== want.divide_by_zero)
                        report_mismatch("divide_by_zero", 32'(out_data.divide_by_zero),
                                        32'(want.divide_by_zero));
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(alu_result(in_data, tolerance));
            if (cfg_write_enable)
                tolerance <= cfg_write_data;
        end
    end

    final
    begin
        if (expected_results.size() != 0)
            $display("%0d results never arrived", expected_results.size());
    end
endmodule

### tb/sv/fixed_point_alu_tolerant_compare_unit_tb.sv
// ---------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives directed and random operations under several tolerances with random
// gaps and stalls on both channels; the checker predicts and compares.
// ---------------------------------------------------------------------------
module fixed_point_alu_tolerant_compare_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 8;
    localparam int LATENCY = FRAC_BITS + 35;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_enable = 1'b0;
    logic [7:0]            cfg_write_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    fpa_tc_pkg::in_item_t  in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b1;
    fpa_tc_pkg::out_item_t out_data;
    int                    fail_count;
    int                    pending_count;
    bit                    long_hold = 1'b0;
    bit                    drain_phase = 1'b0;

    always #2 clk = ~clk;

    fixed_point_alu_tolerant_compare_unit #(.FRAC_BITS(FRAC_BITS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    fixed_point_alu_tolerant_compare_unit_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 600) - 300;
            3: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
            default: return $urandom;
        endcase
    endfunction

    // Holds valid high until the transfer completes. Valid stays high after
    // the transfer; a following gap or an idle wait drops it.
    task automatic send_operation(fpa_tc_pkg::mode_t mode, logic [31:0] a,
                                  logic [31:0] b, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 16) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= '{mode: mode, operand_a: a, operand_b: b};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [7:0] value);
        wait_idle();
        cfg_write_enable <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    // Result side: random stalls, stretches without stalls, one long hold-off.
    initial
    begin
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                long_hold = 1'b0;
            end
            wait_cycles = drain_phase ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 2) == 0)
                wait_cycles = 0;
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        logic [31:0] extremes[6];
        logic [7:0]  tolerances[5];
        extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h100};
        tolerances = '{8'd0, 8'd255, 8'd1, 8'd17, 8'd128};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes in every mode, zero divisor, tolerance edges.
        for (int i = 0; i < 6; i++)
            send_operation(fpa_tc_pkg::mode_t'(i % 4), extremes[i], extremes[5 - i], 1'b0);
        send_operation(fpa_tc_pkg::MODE_DIV, 32'h1234, 32'h0, 1'b0);
        send_operation(fpa_tc_pkg::MODE_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_operation(fpa_tc_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_operation(fpa_tc_pkg::MODE_MUL, 32'hFFFF_FFFF, 32'h1, 1'b0);
        send_operation(fpa_tc_pkg::MODE_ADD, 32'h7FFF_FFFF, 32'h1, 1'b0);
        send_operation(fpa_tc_pkg::MODE_SUB, 32'h8000_0000, 32'h1, 1'b0);
        write_tolerance(8'd255);
        send_operation(fpa_tc_pkg::MODE_SUB, 32'd355, 32'd100, 1'b0);
        send_operation(fpa_tc_pkg::MODE_SUB, 32'd356, 32'd100, 1'b0);
        send_operation(fpa_tc_pkg::MODE_ADD, 32'd100, 32'd355, 1'b0);
        send_operation(fpa_tc_pkg::MODE_ADD, 32'd100, 32'd356, 1'b0);
        send_operation(fpa_tc_pkg::MODE_DIV, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_operation(fpa_tc_pkg::MODE_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);

        // The sender keeps offering while the result side holds off.
        long_hold = 1'b1;
        for (int i = 0; i < 100; i++)
            send_operation(fpa_tc_pkg::mode_t'($urandom_range(0, 3)), random_operand(),
                           random_operand(), 1'b0);

        for (int phase = 0; phase < 5; phase++)
        begin
            write_tolerance(tolerances[phase]);
            for (int i = 0; i < 300; i++)
            begin
                logic [31:0] a;
                logic [31:0] b;
                a = random_operand();
                b = random_operand();
                if ($urandom_range(0, 3) == 0)
                    b = a + $urandom_range(0, 600) - 300;
                if ($urandom_range(0, 15) == 0)
                    b = 0;
                send_operation(fpa_tc_pkg::mode_t'($urandom_range(0, 3)), a, b,
                               i % 100 >= 40);
            end
        end

        drain_phase = 1'b1;
        wait_idle();
        if (fail_count == 0 && pending_count == 0)
            $display("fixed_point_alu_tolerant_compare_unit_tb passed");
        else
            $display("fixed_point_alu_tolerant_compare_unit_tb failed");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("fixed_point_alu_tolerant_compare_unit_tb failed");
        $finish;
    end
endmodule
